@@ hw/rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the keyboard decoder rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALW(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ps2kbd_pkg.sv @@
// ---------------------------------------------------------------------------
// ps2kbd_pkg
// shared constants and types of the keyboard receiver and decoder
// ---------------------------------------------------------------------------
package ps2kbd_pkg;

  localparam logic [7:0] CODE_RELEASE = 8'hF0;
  localparam logic [7:0] CODE_LSHIFT  = 8'h12;
  localparam logic [7:0] CODE_RSHIFT  = 8'h59;
  localparam logic [7:0] CODE_CTRL    = 8'h14;
  localparam logic [7:0] CODE_ALT     = 8'h11;
  localparam logic [7:0] CHAR_ESC     = 8'h1B;
  localparam logic [3:0] DATA_BITS    = 4'd8;

  localparam logic       ACT_EDGE  = 1'b0;
  localparam logic       ACT_WRITE = 1'b1;

  localparam logic [1:0] TBL_PLAIN = 2'd0;
  localparam logic [1:0] TBL_SHIFT = 2'd1;
  localparam logic [1:0] TBL_CTRL  = 2'd2;
  localparam logic [1:0] TBL_NONE  = 2'd3;

  localparam int unsigned TBL_ENTRIES = 768;
  localparam int unsigned FIFO_DEPTH  = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       alt;
  } key_ent_t;

endpackage

@@ hw/rtl/ps2kbd_front.sv @@
// ---------------------------------------------------------------------------
// ps2kbd_front
// frame receiver, modifier tracking and character table lookup
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2kbd_front import ps2kbd_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_action_i,
  input  logic            in_bit_i,
  input  logic [1:0]      in_sel_i,
  input  logic [7:0]      in_idx_i,
  input  logic [7:0]      in_val_i,
  input  logic [CntW-1:0] fifo_cnt_i,
  output logic            push_o,
  output key_ent_t        push_data_o
);

  logic       frame_q, frame_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] sreg_q, sreg_d;
  logic       dec_q, dec_d;
  logic       rel_q, rel_d;
  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       alt_q, alt_d;
  logic       stage_v_q;
  logic       stage_alt_q;
  logic [7:0] rd_data_q;

  logic       accept;
  logic       wr_en;
  logic       edge_acc;
  logic       rd_en;
  logic [1:0] rd_sel;
  logic [9:0] rd_addr;
  logic [9:0] wr_addr;
  logic       is_shift;

  logic [7:0] tbl_mem [TBL_ENTRIES];

  assign in_ready_o = ({1'b0, fifo_cnt_i} + (CntW+1)'(stage_v_q)) < (CntW+1)'(Depth);
  assign accept     = in_valid_i & in_ready_o;
  assign wr_en      = accept & (in_action_i == ACT_WRITE) & (in_sel_i != TBL_NONE);
  assign edge_acc   = accept & (in_action_i == ACT_EDGE);
  assign wr_addr    = {in_sel_i, in_idx_i};
  assign rd_sel     = ctrl_q ? TBL_CTRL : (shift_q ? TBL_SHIFT : TBL_PLAIN);
  assign rd_addr    = {rd_sel, sreg_q};
  assign is_shift   = (sreg_q == CODE_LSHIFT) || (sreg_q == CODE_RSHIFT);

  always_comb begin
    frame_d = frame_q;
    cnt_d   = cnt_q;
    sreg_d  = sreg_q;
    dec_d   = dec_q;
    rel_d   = rel_q;
    shift_d = shift_q;
    ctrl_d  = ctrl_q;
    alt_d   = alt_q;
    rd_en   = 1'b0;
    if (edge_acc) begin
      if (!frame_q) begin
        if (!in_bit_i) begin
          frame_d = 1'b1;
          cnt_d   = '0;
          sreg_d  = '0;
          dec_d   = 1'b0;
        end
      end else if (cnt_q < DATA_BITS) begin
        sreg_d = {in_bit_i, sreg_q[7:1]};
        cnt_d  = cnt_q + 4'd1;
      end else if (!dec_q) begin
        dec_d = 1'b1;
        if (rel_q) begin
          rel_d = 1'b0;
          if (is_shift) shift_d = 1'b0;
          if (sreg_q == CODE_CTRL) ctrl_d = 1'b0;
          if (sreg_q == CODE_ALT) alt_d = 1'b0;
        end else if (sreg_q == CODE_RELEASE) begin
          rel_d = 1'b1;
        end else if (is_shift) begin
          shift_d = 1'b1;
        end else if (sreg_q == CODE_CTRL) begin
          ctrl_d = 1'b1;
        end else if (sreg_q == CODE_ALT) begin
          alt_d = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end else begin
        frame_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= 1'b0;
      cnt_q     <= '0;
      sreg_q    <= '0;
      dec_q     <= 1'b0;
      rel_q     <= 1'b0;
      shift_q   <= 1'b0;
      ctrl_q    <= 1'b0;
      alt_q     <= 1'b0;
      stage_v_q <= 1'b0;
    end else begin
      frame_q   <= frame_d;
      cnt_q     <= cnt_d;
      sreg_q    <= sreg_d;
      dec_q     <= dec_d;
      rel_q     <= rel_d;
      shift_q   <= shift_d;
      ctrl_q    <= ctrl_d;
      alt_q     <= alt_d;
      stage_v_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_mem[wr_addr] <= in_val_i;
    if (rd_en) begin
      rd_data_q   <= tbl_mem[rd_addr];
      stage_alt_q <= alt_q;
    end
  end

  assign push_o           = stage_v_q;
  assign push_data_o.ch   = rd_data_q;
  assign push_data_o.alt  = stage_alt_q;

  // a lookup needs a whole frame, so two never follow each other
  `ASSERT_CHK(a_lookup_spaced, stage_v_q |-> !$past(stage_v_q))
  // the lookup stage always finds room in the queue
  `ASSERT_CHK(a_stage_room, stage_v_q |-> (fifo_cnt_i != CntW'(Depth)))

endmodule

@@ hw/rtl/ps2kbd_fifo.sv @@
// ---------------------------------------------------------------------------
// ps2kbd_fifo
// short queue of looked-up keys between front and back
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2kbd_fifo import ps2kbd_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH,
  localparam int unsigned PtrW = $clog2(Depth),
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  key_ent_t        push_data_i,
  input  logic            pop_i,
  output key_ent_t        head_o,
  output logic            empty_o,
  output logic [CntW-1:0] cnt_o
);

  key_ent_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i) rd_ptr_q <= ptr_inc(rd_ptr_q);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

  `ASSERT_CHK(a_no_overflow, push_i |-> (cnt_q != CntW'(Depth)))
  `ASSERT_CHK(a_no_underflow, pop_i |-> !empty_o)

endmodule

@@ hw/rtl/ps2kbd_back.sv @@
// ---------------------------------------------------------------------------
// ps2kbd_back
// expands queued keys into output beats, escape prefix first when alt held
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2kbd_back import ps2kbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  key_ent_t   head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  typedef enum logic [1:0] {
    BK_NEXT = 2'b01,
    BK_TAIL = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic        valid_q, valid_d;
  logic [7:0]  char_q, char_d;
  logic        last_q, last_d;
  logic [7:0]  tail_q, tail_d;
  logic        load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    tail_d  = tail_q;
    pop_o   = 1'b0;
    if (load) begin
      case (state_q)
        BK_TAIL: begin
          valid_d = 1'b1;
          char_d  = tail_q;
          last_d  = 1'b1;
          state_d = BK_NEXT;
        end
        BK_NEXT: begin
          valid_d = !empty_i;
          if (!empty_i) begin
            pop_o = 1'b1;
            if (head_i.alt) begin
              char_d  = CHAR_ESC;
              last_d  = 1'b0;
              tail_d  = head_i.ch;
              state_d = BK_TAIL;
            end else begin
              char_d = head_i.ch;
              last_d = 1'b1;
            end
          end
        end
        default: begin
          valid_d = 1'b0;
          state_d = BK_NEXT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_NEXT;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // while the character waits, the escape beat sits in the output register
  `ASSERT_CHK(a_tail_after_esc, (state_q == BK_TAIL) |-> (valid_q && !last_q))

endmodule

@@ hw/rtl/ps2_keyboard_receiver_decoder.sv @@
// ---------------------------------------------------------------------------
// ps2_keyboard_receiver_decoder
// ps/2 keyboard frame receiver and scancode set 2 decoder
// ---------------------------------------------------------------------------
// input stream: each beat is one keyboard clock edge with its sampled data
// bit (tuser low) or one write into the plain, shifted or control character
// table (tuser high). a zero bit while idle starts a frame, eight data bits
// follow lsb first, the parity edge decodes, the next edge ends the frame.
// output stream: one beat per character, tlast high on the final one; with
// alt held an escape beat (tlast low) comes first.
// one input beat is taken every cycle while tready is high; the table lookup
// is registered in the front, then a character passes the queue and the output
// register. a queue of FIFO_DEPTH keys sits between decoder and output stage;
// input tready drops only when that queue and the lookup stage together hold
// FIFO_DEPTH keys, which a stall on m_axis_tready causes after a few keys.
// reset returns the receiver to idle and clears all modifiers; table
// contents are kept undefined until written, so write before decoding.
// ---------------------------------------------------------------------------
module ps2_keyboard_receiver_decoder import ps2kbd_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_bit, table_select[1:0], table_index[7:0],
                                     // table_value[7:0], zero pad
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // char_code[7:0]
  output logic        m_axis_tlast
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  logic            push;
  key_ent_t        push_data;
  logic            pop;
  key_ent_t        head;
  logic            empty;
  logic [CntW-1:0] fifo_cnt;

  ps2kbd_front #(
    .Depth(Depth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_bit_i    (s_axis_tdata[0]),
    .in_sel_i    (s_axis_tdata[2:1]),
    .in_idx_i    (s_axis_tdata[10:3]),
    .in_val_i    (s_axis_tdata[18:11]),
    .fifo_cnt_i  (fifo_cnt),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ps2kbd_fifo #(
    .Depth(Depth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .cnt_o       (fifo_cnt)
  );

  ps2kbd_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// stream-level test of the ps/2 keyboard receiver and scancode decoder
// ---------------------------------------------------------------------------
// all three character tables are loaded first, then a short directed list
// walks modifiers, escape prefix, release handling and idle noise, then
// random frames, broken frames, noise and table writes follow. a local decoder
// model predicts every character beat a directed row does not give itself;
// the output side is checked in order with random back-pressure and one long hold.
// ---------------------------------------------------------------------------
module tb;
  import ps2kbd_pkg::*;

  localparam int RAND_BEATS     = 940;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } char_beat_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_KEY,
    ROW_NOISE
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic [1:0] sel;
    logic [7:0] code;
    logic [7:0] val;
    logic       typed;
    logic [1:0] n_typed;
    logic [7:0] e0;
    logic [7:0] e1;
  } dir_row_t;

  localparam dir_row_t DIRECTED [28] = '{
    '{ROW_WRITE, TBL_PLAIN, 8'h1C, 8'h61, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, TBL_NONE,  8'h1C, 8'hEE, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b1, 2'd1, 8'h61, 8'h00},
    '{ROW_NOISE, TBL_PLAIN, 8'h00, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_LSHIFT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, TBL_SHIFT, 8'h1C, 8'h41, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b1, 2'd1, 8'h41, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_CTRL, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, TBL_CTRL,  8'h1C, 8'h01, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b1, 2'd1, 8'h01, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_ALT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b1, 2'd2, CHAR_ESC, 8'h01},
    '{ROW_KEY,   TBL_PLAIN, CODE_RELEASE, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_CTRL, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_RELEASE, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_LSHIFT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, TBL_PLAIN, 8'hFF, 8'hFF, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'hFF, 8'h00, 1'b1, 2'd2, CHAR_ESC, 8'hFF},
    '{ROW_KEY,   TBL_PLAIN, CODE_RELEASE, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_ALT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_WRITE, TBL_PLAIN, 8'h00, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h00, 8'h00, 1'b1, 2'd1, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_RSHIFT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_RELEASE, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, 8'h1C, 8'h00, 1'b0, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_RELEASE, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00},
    '{ROW_KEY,   TBL_PLAIN, CODE_RSHIFT, 8'h00, 1'b1, 2'd0, 8'h00, 8'h00}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // data_bit, table_select[1:0], table_index[7:0],
                                   // table_value[7:0], zero pad
  logic        s_axis_tuser = 1'b0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // char_code[7:0]
  logic        m_axis_tlast;

  // decoder model state
  logic       frame_on = 1'b0;
  logic [3:0] bit_cnt = '0;
  logic [7:0] shreg = '0;
  logic       decoded = 1'b0;
  logic       release_seen = 1'b0;
  logic       shift_hold = 1'b0;
  logic       ctrl_on = 1'b0;
  logic       alt_on = 1'b0;
  logic [7:0] char_mem [3][256];

  char_beat_t due_chars [$];
  int errors = 0;
  int beats_sent = 0;
  int frames_sent = 0;
  int writes_sent = 0;
  int chars_checked = 0;
  int burst_left = 0;
  logic hold_req = 1'b0;

  ps2_keyboard_receiver_decoder DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  always #2 clk_i = ~clk_i;

  task automatic flag_error(input string what);
    $display("ERROR at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [23:0] pack_beat(input logic data_bit, input logic [1:0] sel,
                                            input logic [7:0] idx, input logic [7:0] val);
    return {5'b0, val, idx, sel, data_bit};
  endfunction

  function automatic int decode_beat(input logic act, input logic [23:0] d,
                                     output char_beat_t c0, output char_beat_t c1);
    logic [1:0] sel;
    logic [7:0] code;
    logic [7:0] ch;
    int n;
    sel = d[2:1];
    n = 0;
    c0 = '0;
    c1 = '0;
    if (act == ACT_WRITE) begin
      if (sel != TBL_NONE) char_mem[sel][d[10:3]] = d[18:11];
      return 0;
    end
    if (!frame_on) begin
      if (!d[0]) begin
        frame_on = 1'b1;
        bit_cnt = '0;
        shreg = '0;
        decoded = 1'b0;
      end
      return 0;
    end
    if (bit_cnt < DATA_BITS) begin
      shreg = {d[0], shreg[7:1]};
      bit_cnt++;
      return 0;
    end
    if (decoded) begin
      frame_on = 1'b0;
      return 0;
    end
    decoded = 1'b1;
    code = shreg;
    if (release_seen) begin
      release_seen = 1'b0;
      if (code == CODE_LSHIFT || code == CODE_RSHIFT) shift_hold = 1'b0;
      if (code == CODE_CTRL) ctrl_on = 1'b0;
      if (code == CODE_ALT) alt_on = 1'b0;
      return 0;
    end
    case (code)
      CODE_RELEASE: release_seen = 1'b1;
      CODE_LSHIFT, CODE_RSHIFT: shift_hold = 1'b1;
      CODE_CTRL: ctrl_on = 1'b1;
      CODE_ALT: alt_on = 1'b1;
      default: begin
        if (ctrl_on) ch = char_mem[TBL_CTRL][code];
        else if (shift_hold) ch = char_mem[TBL_SHIFT][code];
        else ch = char_mem[TBL_PLAIN][code];
        if (alt_on) begin
          c0 = '{CHAR_ESC, 1'b0};
          c1 = '{ch, 1'b1};
          n = 2;
        end else begin
          c0 = '{ch, 1'b1};
          n = 1;
        end
      end
    endcase
    return n;
  endfunction

  task automatic send_beat(input logic act, input logic [23:0] d, input logic typed,
                           input logic [1:0] n_typed, input logic [7:0] t0,
                           input logic [7:0] t1);
    char_beat_t c0, c1;
    int n;
    s_axis_tuser <= act;
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = decode_beat(act, d, c0, c1);
    if (typed) begin
      n = int'(n_typed);
      if (n == 2) begin
        c0 = '{t0, 1'b0};
        c1 = '{t1, 1'b1};
      end else begin
        c0 = '{t0, 1'b1};
      end
    end
    if (n > 0) due_chars.push_back(c0);
    if (n > 1) due_chars.push_back(c1);
    beats_sent++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_edge(input logic data_bit);
    send_beat(ACT_EDGE, pack_beat(data_bit, 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
              1'b0, 2'd0, 8'h00, 8'h00);
  endtask

  task automatic send_write(input logic [1:0] sel, input logic [7:0] idx, input logic [7:0] val);
    send_beat(ACT_WRITE, pack_beat(1'($urandom_range(0, 1)), sel, idx, val), 1'b0, 2'd0,
              8'h00, 8'h00);
    writes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] code, input logic parity, input logic stop,
                            input logic typed, input logic [1:0] n_typed,
                            input logic [7:0] e0, input logic [7:0] e1);
    send_edge(1'b0);
    for (int i = 0; i < 8; i++) send_edge(code[i]);
    send_beat(ACT_EDGE, pack_beat(parity, 2'($urandom_range(0, 3)),
              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))),
              typed, n_typed, e0, e1);
    send_edge(stop);
    frames_sent++;
  endtask

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 3))
      0: return CODE_LSHIFT;
      1: return CODE_RSHIFT;
      2: return CODE_CTRL;
      default: return CODE_ALT;
    endcase
  endfunction

  initial begin
    dir_row_t row;
    logic [7:0] code;
    int pick;
    int base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    burst_left = $urandom_range(0, 16);

    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < 256; i++) send_write(2'(s), 8'(i), 8'($urandom_range(0, 255)));
    end

    for (int i = 0; i < 28; i++) begin
      row = DIRECTED[i];
      case (row.kind)
        ROW_WRITE: send_write(row.sel, row.code, row.val);
        ROW_KEY: send_frame(row.code, ~^row.code, 1'b1, row.typed, row.n_typed, row.e0, row.e1);
        default: send_edge(1'b1);
      endcase
    end

    hold_req = 1'b1;
    base = beats_sent;
    while (beats_sent - base < RAND_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        case ($urandom_range(0, 15))
          0: code = pick_modifier();
          1, 2: begin
            send_frame(CODE_RELEASE, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 2'd0,
                       8'h00, 8'h00);
            code = pick_modifier();
          end
          3: code = CODE_RELEASE;
          default: code = 8'($urandom_range(0, 255));
        endcase
        send_frame(code, 1'($urandom_range(0, 1)), ($urandom_range(0, 7) != 0), 1'b0, 2'd0,
                   8'h00, 8'h00);
      end else if (pick < 80) begin
        send_write(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) send_edge(1'b1);
      end else begin
        send_edge(1'b0);
        repeat ($urandom_range(0, 10)) send_edge(1'($urandom_range(0, 1)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (due_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d beats: %0d key frames, %0d table writes, noise and broken frames",
             beats_sent, frames_sent, writes_sent);
    $display("%0d character beats checked, %0d mismatches", chars_checked, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // output side back-pressure, with a long hold when asked
  initial begin
    int len;
    int mode;
    logic [15:0] pat;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(8, 64);
        pat = 16'($urandom);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0, 1: m_axis_tready <= 1'b1;
            2: m_axis_tready <= pat[k % 16];
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    char_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_chars.size() == 0) begin
        flag_error($sformatf("unexpected char beat %02h last %0b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = due_chars.pop_front();
        if (m_axis_tdata !== want.ch)
          flag_error($sformatf("char %02h, want %02h", m_axis_tdata, want.ch));
        if (m_axis_tlast !== want.is_last)
          flag_error($sformatf("tlast %0b, want %0b", m_axis_tlast, want.is_last));
        chars_checked++;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    flag_error($sformatf("no beat accepted for %0d cycles, %0d chars outstanding",
                         WATCHDOG_LIMIT, due_chars.size()));
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ps2kbd_pkg.sv
hw/rtl/ps2kbd_front.sv
hw/rtl/ps2kbd_fifo.sv
hw/rtl/ps2kbd_back.sv
hw/rtl/ps2_keyboard_receiver_decoder.sv
test/tb.sv
